// ===== hdl/pcx_pkg.sv =====
// shared constants, codes and control structs of the pcx rle decoder
`timescale 1ns / 1ps
package pcx_pkg;

  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int X_W   = 10;
  localparam int Y_W   = 9;
  localparam int HDR_W = 16;
  localparam int IDX_W = 7;

  localparam logic [IDX_W-1:0] HDR_LAST = 7'd127;

  localparam logic [7:0] MANUF_ID  = 8'h0A;
  localparam logic [7:0] VERSION   = 8'd5;
  localparam logic [7:0] ENCODING  = 8'd1;
  localparam logic [7:0] BITS_PIX  = 8'd8;
  localparam logic [7:0] RUN_MARK  = 8'hC0;
  localparam logic [7:0] RUN_MASK  = 8'h3F;

  localparam logic [IDX_W-1:0] IDX_MANUF = 7'd0;
  localparam logic [IDX_W-1:0] IDX_VER   = 7'd1;
  localparam logic [IDX_W-1:0] IDX_ENC   = 7'd2;
  localparam logic [IDX_W-1:0] IDX_BPP   = 7'd3;
  localparam logic [IDX_W-1:0] IDX_XLO   = 7'd8;
  localparam logic [IDX_W-1:0] IDX_XHI   = 7'd9;
  localparam logic [IDX_W-1:0] IDX_YLO   = 7'd10;
  localparam logic [IDX_W-1:0] IDX_YHI   = 7'd11;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_HDR_OK = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  typedef struct packed {
    logic take;
    logic clear;
  } hdr_ctrl_t;

  typedef struct packed {
    logic last;
    logic good;
  } hdr_stat_t;

  typedef struct packed {
    logic clear;
    logic step;
  } pos_ctrl_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last_col;
    logic             last_img;
  } pos_stat_t;

endpackage

// ===== hdl/pcx_hdr.sv =====
// header collector and checker of the pcx rle decoder
`timescale 1ns / 1ps
module pcx_hdr
  import pcx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  hdr_ctrl_t        ctrl,
  input  logic [7:0]       raw_byte,
  output hdr_stat_t        stat,
  output logic [HDR_W-1:0] xmax,
  output logic [HDR_W-1:0] ymax
);

  logic [IDX_W-1:0] index;
  logic             valid;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      index <= '0;
      valid <= 1'b1;
      xmax  <= '0;
      ymax  <= '0;
    end else if (ctrl.take) begin
      if ((index == IDX_MANUF && raw_byte != MANUF_ID) ||
          (index == IDX_VER && raw_byte != VERSION) ||
          (index == IDX_ENC && raw_byte != ENCODING) ||
          (index == IDX_BPP && raw_byte != BITS_PIX)) begin
        valid <= 1'b0;
      end
      if (index == IDX_XLO) xmax[7:0]  <= raw_byte;
      if (index == IDX_XHI) xmax[15:8] <= raw_byte;
      if (index == IDX_YLO) ymax[7:0]  <= raw_byte;
      if (index == IDX_YHI) ymax[15:8] <= raw_byte;
      if (index == HDR_LAST) begin
        index <= '0;
      end else begin
        index <= IDX_W'(index + 1'b1);
      end
    end
  end

  assign stat.last = (index == HDR_LAST);
  assign stat.good = valid && (xmax < HDR_W'(MAX_WIDTH)) && (ymax < HDR_W'(MAX_HEIGHT));

endmodule

// ===== hdl/pcx_pos.sv =====
// shared pixel position unit: column and row counters with end-of-row compare
`timescale 1ns / 1ps
module pcx_pos
  import pcx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pos_ctrl_t        ctrl,
  input  logic [HDR_W-1:0] xmax,
  input  logic [HDR_W-1:0] ymax,
  output pos_stat_t        stat
);

  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic             last_col;

  assign last_col = HDR_W'(column) >= xmax;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      column <= '0;
      row    <= '0;
    end else if (ctrl.step) begin
      if (last_col) begin
        column <= '0;
        row    <= ROW_W'(row + 1'b1);
      end else begin
        column <= COL_W'(column + 1'b1);
      end
    end
  end

  assign stat.column   = column;
  assign stat.row      = row;
  assign stat.last_col = last_col;
  assign stat.last_img = last_col && (HDR_W'(row) >= ymax);

endmodule

// ===== hdl/pcx_rle_image_decoder.sv =====
// top level of the pcx rle decoder: byte sequencer and output register
`timescale 1ns / 1ps
// Takes a PCX file one byte per word on the slave side and produces result words on the
// master side: a header accept (with image size) or reject after the 128-byte header, then
// one word per decoded pixel with its column and row, and a truncation word if the file ends
// before the image is complete. A byte that yields results holds off the next byte until all
// of its results have been loaded into the output register, since pixels leave one per cycle
// through the single shared column/row counter while the master side accepts them; a full run
// of 63 pixels cut short by the end of file drops its last pixel before the truncation word.
// Back-pressure on the master side adds wait cycles. After the byte marked with tlast the block
// returns to the header phase.
module pcx_rle_image_decoder
  import pcx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // raw file byte
  input  logic        s_axis_tlast,  // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value, pixel_x, pixel_y, image_width, image_height, 2 bits zero
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // result_kind, image_done
  output logic        m_axis_tlast   // run_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  localparam logic [5:0] RUN_FULL_M1 = 6'd62;

  logic [1:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       pending, pending_next;
  logic [5:0] pend_cnt, pend_cnt_next;
  logic [7:0] byte_hold, byte_hold_next;
  logic       eof_hold, eof_hold_next;
  logic       good_hold, good_hold_next;
  logic [5:0] run_len, run_len_next;
  logic [5:0] emitted, emitted_next;

  logic [1:0]   out_kind, kind_next;
  logic [7:0]   out_value;
  logic [X_W-1:0] out_x, x_next;
  logic [Y_W-1:0] out_y, y_next;
  logic [X_W-1:0] out_w, w_next;
  logic [Y_W-1:0] out_h, h_next;
  logic         out_last, last_next;
  logic         out_done, done_next;
  logic         out_valid, out_load;

  hdr_ctrl_t        hdr_ctrl;
  hdr_stat_t        hdr_stat;
  pos_ctrl_t        pos_ctrl;
  pos_stat_t        pos_stat;
  logic [HDR_W-1:0] xmax, ymax;

  logic       in_acc, slot_free, rearm, stop, drop;
  logic [5:0] cnt;

  pcx_hdr u_hdr (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (hdr_ctrl),
    .raw_byte (s_axis_tdata),
    .stat     (hdr_stat),
    .xmax     (xmax),
    .ymax     (ymax)
  );

  pcx_pos u_pos (
    .clk  (clk),
    .rst  (rst),
    .ctrl (pos_ctrl),
    .xmax (xmax),
    .ymax (ymax),
    .stat (pos_stat)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;

  assign stop = (6'(emitted + 6'd1) == run_len) || pos_stat.last_col;
  assign drop = eof_hold && (emitted == RUN_FULL_M1) && !pos_stat.last_img;

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    pending_next   = pending;
    pend_cnt_next  = pend_cnt;
    byte_hold_next = byte_hold;
    eof_hold_next  = eof_hold;
    good_hold_next = good_hold;
    run_len_next   = run_len;
    emitted_next   = emitted;
    hdr_ctrl       = '0;
    pos_ctrl       = '0;
    rearm          = 1'b0;
    cnt            = '0;
    out_load       = 1'b0;
    kind_next      = KIND_PIXEL;
    x_next         = '0;
    y_next         = '0;
    w_next         = '0;
    h_next         = '0;
    last_next      = 1'b0;
    done_next      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          byte_hold_next = s_axis_tdata;
          eof_hold_next  = s_axis_tlast;
          unique case (phase)
            PH_HEADER: begin
              hdr_ctrl.take = 1'b1;
              if (hdr_stat.last) begin
                good_hold_next = hdr_stat.good;
                state_next     = ST_HDR;
                if (hdr_stat.good) begin
                  phase_next     = PH_DECODE;
                  pos_ctrl.clear = 1'b1;
                  pending_next   = 1'b0;
                end else begin
                  phase_next = PH_SKIP;
                end
              end else if (s_axis_tlast) begin
                state_next = ST_TRUNC;
              end
            end
            PH_DECODE: begin
              if (pending) begin
                cnt          = pend_cnt;
                pending_next = 1'b0;
              end else if ((s_axis_tdata & RUN_MARK) == RUN_MARK) begin
                pending_next  = 1'b1;
                pend_cnt_next = 6'(s_axis_tdata & RUN_MASK);
              end else begin
                cnt = 6'd1;
              end
              run_len_next = cnt;
              emitted_next = '0;
              if (cnt != '0) begin
                state_next = ST_RUN;
              end else if (s_axis_tlast) begin
                state_next = ST_TRUNC;
              end
            end
            default: begin
              rearm = s_axis_tlast;
            end
          endcase
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          out_load  = 1'b1;
          kind_next = good_hold ? KIND_HDR_OK : KIND_HDR_BAD;
          if (good_hold) begin
            w_next = X_W'(xmax + 16'd1);
            h_next = Y_W'(ymax + 16'd1);
          end
          last_next = !(good_hold && eof_hold);
          if (good_hold && eof_hold) begin
            state_next = ST_TRUNC;
          end else begin
            state_next = ST_IDLE;
            rearm      = eof_hold;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          if (drop) begin
            state_next = ST_TRUNC;
          end else begin
            out_load      = 1'b1;
            kind_next     = KIND_PIXEL;
            x_next        = X_W'(pos_stat.column);
            y_next        = Y_W'(pos_stat.row);
            done_next     = pos_stat.last_img;
            last_next     = stop && !(eof_hold && !pos_stat.last_img);
            pos_ctrl.step = 1'b1;
            emitted_next  = 6'(emitted + 6'd1);
            if (stop) begin
              if (pos_stat.last_img) begin
                phase_next = PH_SKIP;
              end
              if (eof_hold && !pos_stat.last_img) begin
                state_next = ST_TRUNC;
              end else begin
                state_next = ST_IDLE;
                rearm      = eof_hold;
              end
            end
          end
        end
      end
      default: begin
        if (slot_free) begin
          out_load   = 1'b1;
          kind_next  = KIND_TRUNC;
          last_next  = 1'b1;
          state_next = ST_IDLE;
          rearm      = 1'b1;
        end
      end
    endcase

    // end of file returns to the header phase
    if (rearm) begin
      phase_next     = PH_HEADER;
      pending_next   = 1'b0;
      pend_cnt_next  = '0;
      hdr_ctrl.clear = 1'b1;
      pos_ctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_HEADER;
      pending   <= 1'b0;
      pend_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      pending  <= pending_next;
      pend_cnt <= pend_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_hold <= byte_hold_next;
    eof_hold  <= eof_hold_next;
    good_hold <= good_hold_next;
    run_len   <= run_len_next;
    emitted   <= emitted_next;
    if (out_load) begin
      out_kind  <= kind_next;
      out_value <= (kind_next == KIND_PIXEL) ? byte_hold : 8'd0;
      out_x     <= x_next;
      out_y     <= y_next;
      out_w     <= w_next;
      out_h     <= h_next;
      out_last  <= last_next;
      out_done  <= done_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_h, out_w, out_y, out_x, out_value};
  assign m_axis_tuser  = {out_done, out_kind};
  assign m_axis_tlast  = out_last;

endmodule

// ===== bench/tb_pcx_rle_image_decoder.sv =====
// testbench of the pcx rle decoder: header, rle stream and truncation words checked in order
`timescale 1ns / 1ps
module tb_pcx_rle_image_decoder;
  import pcx_pkg::*;

  typedef enum logic [1:0] {ST_HEADER, ST_PIXELS, ST_IGNORE} decode_phase_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [7:0]     value;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [X_W-1:0] width;
    logic [Y_W-1:0] height;
    logic           last;
    logic           done;
  } pcx_word_t;

  localparam int MAX_BURST = 63;

  class pcx_scoreboard;
    decode_phase_t phase;
    int            hdr_idx;
    bit            hdr_ok;
    logic [15:0]   xmax;
    logic [15:0]   ymax;
    int            col;
    int            row;
    bit            count_pending;
    int            pending_count;
    pcx_word_t     burst[$];
    pcx_word_t     expected_words[$];
    int            mismatches;
    int            words_checked;
    int            kind_seen[4];

    function new();
      mismatches = 0;
      words_checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      rearm();
    endfunction

    function void rearm();
      phase = ST_HEADER;
      hdr_idx = 0;
      hdr_ok = 1'b1;
      xmax = '0;
      ymax = '0;
      col = 0;
      row = 0;
      count_pending = 1'b0;
      pending_count = 0;
    endfunction

    function void add_word(logic [1:0] kind, int val, int x, int y, int w, int h, bit done);
      pcx_word_t wd;
      if (burst.size() >= MAX_BURST) return;
      wd.kind   = kind;
      wd.value  = 8'(val);
      wd.x      = X_W'(x);
      wd.y      = Y_W'(y);
      wd.width  = X_W'(w);
      wd.height = Y_W'(h);
      wd.last   = 1'b0;
      wd.done   = done;
      burst.push_back(wd);
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      int        cnt;
      int        k;
      bit        have;
      bit        row_end;
      bit        fin;
      bit        last_col;
      bit        last_img;
      pcx_word_t wd;
      burst.delete();
      if (phase == ST_HEADER) begin
        if ((hdr_idx == IDX_MANUF && b != MANUF_ID) || (hdr_idx == IDX_VER && b != VERSION) ||
            (hdr_idx == IDX_ENC && b != ENCODING) || (hdr_idx == IDX_BPP && b != BITS_PIX))
          hdr_ok = 1'b0;
        if (hdr_idx == IDX_XLO) xmax[7:0] = b;
        if (hdr_idx == IDX_XHI) xmax[15:8] = b;
        if (hdr_idx == IDX_YLO) ymax[7:0] = b;
        if (hdr_idx == IDX_YHI) ymax[15:8] = b;
        if (hdr_idx >= HDR_LAST) begin
          if (hdr_ok && xmax < MAX_WIDTH && ymax < MAX_HEIGHT) begin
            add_word(KIND_HDR_OK, 0, 0, 0, xmax + 1, ymax + 1, 1'b0);
            phase = ST_PIXELS;
            col = 0;
            row = 0;
            count_pending = 1'b0;
            pending_count = 0;
            if (eof) add_word(KIND_TRUNC, 0, 0, 0, 0, 0, 1'b0);
          end else begin
            add_word(KIND_HDR_BAD, 0, 0, 0, 0, 0, 1'b0);
            phase = ST_IGNORE;
          end
          hdr_idx = 0;
        end else begin
          hdr_idx++;
          if (eof) add_word(KIND_TRUNC, 0, 0, 0, 0, 0, 1'b0);
        end
      end else if (phase == ST_PIXELS) begin
        cnt = 0;
        have = 1'b0;
        if (count_pending) begin
          cnt = pending_count;
          count_pending = 1'b0;
          have = 1'b1;
        end else if ((b & RUN_MARK) == RUN_MARK) begin
          count_pending = 1'b1;
          pending_count = int'(b & RUN_MASK);
        end else begin
          cnt = 1;
          have = 1'b1;
        end
        if (have) begin
          row_end = 1'b0;
          fin = 1'b0;
          for (k = 0; k < cnt && !row_end; k++) begin
            last_col = col >= xmax;
            last_img = last_col && row >= ymax;
            add_word(KIND_PIXEL, b, col, row, 0, 0, last_img);
            if (last_col) begin
              row_end = 1'b1;
              fin = last_img;
            end else begin
              col++;
            end
          end
          if (row_end) begin
            col = 0;
            row++;
          end
          if (fin) phase = ST_IGNORE;
        end
        if (eof && phase == ST_PIXELS) begin
          // no room for the truncation word: the run loses its last pixel
          if (burst.size() >= MAX_BURST) void'(burst.pop_back());
          add_word(KIND_TRUNC, 0, 0, 0, 0, 0, 1'b0);
        end
      end
      if (burst.size() > 0) begin
        wd = burst.pop_back();
        wd.last = 1'b1;
        burst.push_back(wd);
      end
      foreach (burst[i]) expected_words.push_back(burst[i]);
      if (eof) rearm();
    endfunction

    function void cmp(string field, int expv, int actv);
      if (expv != actv) begin
        $error("%s: expected %0d, actual %0d", field, expv, actv);
        mismatches++;
      end
    endfunction

    function void check_word(logic [47:0] data, logic [2:0] user, logic last);
      pcx_word_t ew;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: tdata %h tuser %h", data, user);
        mismatches++;
        return;
      end
      ew = expected_words.pop_front();
      words_checked++;
      kind_seen[user[1:0]]++;
      cmp("result_kind", ew.kind, user[1:0]);
      cmp("pixel_value", ew.value, data[7:0]);
      cmp("pixel_x", ew.x, data[17:8]);
      cmp("pixel_y", ew.y, data[26:18]);
      cmp("image_width", ew.width, data[36:27]);
      cmp("image_height", ew.height, data[45:37]);
      cmp("run_last", ew.last, last);
      cmp("image_done", ew.done, user[2]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  pcx_scoreboard sb = new();
  logic [7:0]    file_bytes[$];
  bit            src_quiet = 1'b0;
  int            files_sent = 0;
  int            bytes_sent = 0;

  pcx_rle_image_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int g;
    g = idle_cycles(src_quiet);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_file();
    int i;
    src_quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic add_header(input logic [7:0] manuf, input logic [7:0] ver,
                            input logic [7:0] enc, input logic [7:0] bpp,
                            input logic [15:0] xm, input logic [15:0] ym);
    int base;
    int i;
    base = file_bytes.size();
    for (i = 0; i < 128; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes[base + IDX_MANUF] = manuf;
    file_bytes[base + IDX_VER]   = ver;
    file_bytes[base + IDX_ENC]   = enc;
    file_bytes[base + IDX_BPP]   = bpp;
    file_bytes[base + IDX_XLO]   = xm[7:0];
    file_bytes[base + IDX_XHI]   = xm[15:8];
    file_bytes[base + IDX_YLO]   = ym[7:0];
    file_bytes[base + IDX_YHI]   = ym[15:8];
  endtask

  task automatic good_header(input logic [15:0] xm, input logic [15:0] ym);
    add_header(MANUF_ID, VERSION, ENCODING, BITS_PIX, xm, ym);
  endtask

  task automatic add_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int mode_left;
    bit sink_quiet;
    bit pressure_done;
    stall_left = 0;
    hold_left = 0;
    mode_left = 0;
    sink_quiet = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (mode_left == 0) begin
        sink_quiet = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      // one long hold-off in the middle of a long run so that the decoder backs up
      if (!pressure_done && sb.words_checked >= 8) begin
        hold_left = 300;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_cycles(sink_quiet);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // one-byte file
    file_bytes.push_back(MANUF_ID);
    send_file();
    // file ending inside the header
    good_header(16'd3, 16'd1);
    trim_file(6);
    send_file();
    // 70 by 2 image: zero run, top single value, full, short and clipped runs on the first row
    good_header(16'd69, 16'd1);
    file_bytes.push_back(RUN_MARK);
    file_bytes.push_back(8'h55);
    file_bytes.push_back(8'hBF);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'hC5);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'hC3);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) begin
      // overrun on the final row, then trailing bytes
      file_bytes.push_back(8'hCA);
      file_bytes.push_back(8'($urandom_range(0, 255)));
      add_noise(3);
    end
    // otherwise the file ends on a full run in mid row
    send_file();

    s_axis_tvalid <= 1'b0;
    while (sb.expected_words.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_words.size());
      sb.mismatches++;
    end
    $display("run covered %0d files, %0d input bytes, %0d result words", files_sent, bytes_sent,
             sb.words_checked);
    $display("  %0d pixels, %0d headers accepted, %0d rejected, %0d truncated files",
             sb.kind_seen[KIND_PIXEL], sb.kind_seen[KIND_HDR_OK], sb.kind_seen[KIND_HDR_BAD],
             sb.kind_seen[KIND_TRUNC]);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout waiting for the decoder");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
